[hdl/fbs_pkg.sv]
package fbs_pkg;

   localparam int INDEX_DEPTH       = 4096;
   localparam int SONG_COUNT        = 1024;
   localparam int FRAME_STORE_DEPTH = 65536;
   localparam int QUERY_WORDS       = 256;

   localparam int IDX_AW  = $clog2(INDEX_DEPTH);
   localparam int SONG_AW = $clog2(SONG_COUNT);
   localparam int FS_AW   = $clog2(FRAME_STORE_DEPTH);
   localparam int QB_AW   = (QUERY_WORDS > 1) ? $clog2(QUERY_WORDS) : 1;
   localparam int QC_W    = $clog2(QUERY_WORDS + 1);
   localparam int CNT_W   = 13;
   localparam int DIFF_W  = 14;
   localparam int CSR_IW  = 2;
   localparam int CSR_DW  = 14;

   localparam logic [DIFF_W-1:0] DIFF_SAT = '1;

   typedef enum logic [1:0] {
      ACT_INDEX = 2'd0,
      ACT_SONG  = 2'd1,
      ACT_FRAME = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   localparam logic [CSR_IW-1:0] CSR_INDEX_COUNT = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_MAX_DIFF    = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_FLIP_RADIUS = 2'd2;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_LOAD,
      OP_KEY_RD,
      OP_KEY_CHK,
      OP_BS_RD,
      OP_BS_CMP,
      OP_BK_RD,
      OP_BK_CMP,
      OP_ENT_RD,
      OP_ENT_CHK,
      OP_ALN_CHK,
      OP_SUM_RD,
      OP_SUM_ADD,
      OP_DEC,
      OP_ADVANCE,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic clr_last;
      logic key_zero;
      logic bs_empty;
      logic key_lt;
      logic key_gt;
      logic key_eq;
      logic ptr_zero;
      logic ptr_end;
      logic frame_bad;
      logic len_bad;
      logic sum_last;
      logic sum_ok;
      logic keys_done;
   } status_type;

endpackage

[hdl/fbs_ram.sv]
module fbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/fbs_ctrl.sv]
module fbs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_action,
   input  logic                req_last_query,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   input  fbs_pkg::status_type st,
   output fbs_pkg::op_type     op
);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_KEY_RD, ST_KEY_CHK, ST_BS_RD, ST_BS_CMP, ST_BK_RD,
      ST_BK_CMP, ST_ENT_RD, ST_ENT_CHK, ST_ALN_CHK, ST_SUM_RD, ST_SUM_ADD,
      ST_DEC, ST_ADVANCE, ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      is_last;

   assign is_last = (req_action == fbs_pkg::ACT_QUERY) && req_last_query;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      req_ready    = 1'b0;
      op           = fbs_pkg::OP_IDLE;
      case (state_ff)
         ST_CLEAR: begin
            op = fbs_pkg::OP_CLEAR;
            if (st.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            // A search may start only when the result register is free.
            req_ready = !rsp_valid_ff || !is_last;
            if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
            if (req_valid && req_ready) begin
               op = fbs_pkg::OP_LOAD;
               if (is_last) state_in = ST_KEY_RD;
            end
         end
         ST_KEY_RD: begin
            op       = fbs_pkg::OP_KEY_RD;
            state_in = ST_KEY_CHK;
         end
         ST_KEY_CHK: begin
            op       = fbs_pkg::OP_KEY_CHK;
            state_in = st.key_zero ? ST_ADVANCE : ST_BS_RD;
         end
         ST_BS_RD: begin
            op       = fbs_pkg::OP_BS_RD;
            state_in = st.bs_empty ? ST_ADVANCE : ST_BS_CMP;
         end
         ST_BS_CMP: begin
            op       = fbs_pkg::OP_BS_CMP;
            state_in = (st.key_lt || st.key_gt) ? ST_BS_RD : ST_BK_RD;
         end
         ST_BK_RD: begin
            op       = fbs_pkg::OP_BK_RD;
            state_in = st.ptr_zero ? ST_ENT_RD : ST_BK_CMP;
         end
         ST_BK_CMP: begin
            op       = fbs_pkg::OP_BK_CMP;
            state_in = st.key_eq ? ST_BK_RD : ST_ENT_RD;
         end
         ST_ENT_RD: begin
            op       = fbs_pkg::OP_ENT_RD;
            state_in = st.ptr_end ? ST_ADVANCE : ST_ENT_CHK;
         end
         ST_ENT_CHK: begin
            op = fbs_pkg::OP_ENT_CHK;
            if (!st.key_eq) state_in = ST_ADVANCE;
            else if (st.frame_bad) state_in = ST_ENT_RD;
            else state_in = ST_ALN_CHK;
         end
         ST_ALN_CHK: begin
            op       = fbs_pkg::OP_ALN_CHK;
            state_in = st.len_bad ? ST_ENT_RD : ST_SUM_RD;
         end
         ST_SUM_RD: begin
            op       = fbs_pkg::OP_SUM_RD;
            state_in = ST_SUM_ADD;
         end
         ST_SUM_ADD: begin
            op       = fbs_pkg::OP_SUM_ADD;
            state_in = st.sum_last ? ST_DEC : ST_SUM_RD;
         end
         ST_DEC: begin
            op       = fbs_pkg::OP_DEC;
            state_in = st.sum_ok ? ST_FINISH : ST_ENT_RD;
         end
         ST_ADVANCE: begin
            op       = fbs_pkg::OP_ADVANCE;
            state_in = st.keys_done ? ST_FINISH : ST_KEY_RD;
         end
         ST_FINISH: begin
            op           = fbs_pkg::OP_FINISH;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE))
      else $error("input accepted outside idle");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised without a finished search");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !rsp_valid_ff)
      else $error("search finished over a pending result");

   a_search_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_ready && is_last) |=>
      (state_ff == ST_KEY_RD))
      else $error("last query word did not start a search");

endmodule

[hdl/fbs_datapath.sv]
module fbs_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  fbs_pkg::op_type               op,
   output fbs_pkg::status_type           st,
   input  logic                          csr_valid,
   input  logic [fbs_pkg::CSR_IW-1:0]    csr_index,
   input  logic [fbs_pkg::CSR_DW-1:0]    csr_data,
   input  logic [1:0]                    req_action,
   input  logic [11:0]                   req_entry_slot,
   input  logic [31:0]                   req_word,
   input  logic [9:0]                    req_song_number,
   input  logic [15:0]                   req_frame_in_song,
   input  logic [15:0]                   req_store_address,
   input  logic [16:0]                   req_song_frames,
   input  logic                          req_last_query,
   output logic                          rsp_found,
   output logic [9:0]                    rsp_match_song,
   output logic [13:0]                   rsp_match_diff_bits,
   output logic                          rsp_overflow
);

   localparam int IAW = fbs_pkg::IDX_AW;
   localparam int SAW = fbs_pkg::SONG_AW;
   localparam int FAW = fbs_pkg::FS_AW;
   localparam int QAW = fbs_pkg::QB_AW;
   localparam int QCW = fbs_pkg::QC_W;
   localparam int CW  = fbs_pkg::CNT_W;
   localparam int DW  = fbs_pkg::DIFF_W;

   function automatic logic [5:0] popcount(input logic [31:0] v);
      logic [5:0] total;
      total = '0;
      for (int n = 0; n < 8; n++) begin
         total = total + 6'(v[4*n]) + 6'(v[4*n+1]) + 6'(v[4*n+2]) + 6'(v[4*n+3]);
      end
      return total;
   endfunction

   logic [CW-1:0]  index_count_ff, index_count_in;
   logic [DW-1:0]  max_diff_ff, max_diff_in;
   logic [1:0]     radius_ff, radius_in;
   logic [QCW-1:0] qcount_ff, qcount_in;
   logic           overflow_ff, overflow_in;
   logic [SAW-1:0] clr_ff, clr_in;
   logic [1:0]     pass_ff, pass_in;
   logic [QCW-1:0] i_ff, i_in;
   logic [4:0]     j_ff, j_in, k_ff, k_in;
   logic [31:0]    key_ff, key_in;
   logic [CW-1:0]  lo_ff, lo_in, hx_ff, hx_in, ptr_ff, ptr_in;
   logic [IAW-1:0] mid_ff, mid_in;
   logic [9:0]     song_ff, song_in;
   logic [15:0]    start_ff, start_in;
   logic [FAW-1:0] bstart_ff, bstart_in;
   logic [QCW-1:0] kk_ff, kk_in;
   logic [DW-1:0]  sum_ff, sum_in;
   logic           found_ff, found_in;
   logic           rsp_found_ff, rsp_found_in;
   logic [9:0]     rsp_song_ff, rsp_song_in;
   logic [DW-1:0]  rsp_diff_ff, rsp_diff_in;
   logic           rsp_ovf_ff, rsp_ovf_in;

   logic [CW-1:0]  n_used;
   logic [31:0]    mask, key_next;
   logic [CW:0]    mid_sum;
   logic           last_i, pass_done;
   logic [DW:0]    sum_add;

   logic           idx_we, song_we, fs_we, qb_we;
   logic [IAW-1:0] idx_wa, idx_ra;
   logic [57:0]    idx_wd, idx_rd;
   logic [SAW-1:0] song_wa;
   logic [32:0]    song_wd, song_rd;
   logic [31:0]    fs_rd, qb_rd;
   logic [QAW-1:0] qb_ra;
   logic [31:0]    rd_key;
   logic [9:0]     rd_song;
   logic [15:0]    rd_frame;
   logic [15:0]    rd_base;
   logic [16:0]    rd_len;

   assign rd_key   = idx_rd[57:26];
   assign rd_song  = idx_rd[25:16];
   assign rd_frame = idx_rd[15:0];
   assign rd_base  = song_rd[32:17];
   assign rd_len   = song_rd[16:0];

   assign n_used = (32'(index_count_ff) > fbs_pkg::INDEX_DEPTH) ?
                   CW'(fbs_pkg::INDEX_DEPTH) : index_count_ff;

   always_comb begin
      case (pass_ff)
         2'd1:    mask = 32'd1 << j_ff;
         2'd2:    mask = (32'd1 << j_ff) | (32'd1 << k_ff);
         default: mask = '0;
      endcase
   end

   assign key_next = qb_rd ^ mask;
   assign mid_sum  = ({1'b0, lo_ff} + {1'b0, hx_ff} - (CW+1)'(1)) >> 1;
   assign last_i   = (i_ff == qcount_ff - QCW'(1));
   assign sum_add  = (DW+1)'(sum_ff) + (DW+1)'(popcount(qb_rd ^ fs_rd));

   always_comb begin
      case (pass_ff)
         2'd0:    pass_done = last_i;
         2'd1:    pass_done = last_i && (j_ff == 5'd31);
         default: pass_done = last_i && (j_ff == 5'd30) && (k_ff == 5'd31);
      endcase
   end

   always_comb begin
      st.clr_last  = (32'(clr_ff) == fbs_pkg::SONG_COUNT - 1);
      st.key_zero  = (key_next == '0);
      st.bs_empty  = (lo_ff >= hx_ff);
      st.key_lt    = (key_ff < rd_key);
      st.key_gt    = (key_ff > rd_key);
      st.key_eq    = (key_ff == rd_key);
      st.ptr_zero  = (ptr_ff == '0);
      st.ptr_end   = (ptr_ff >= n_used);
      st.frame_bad = (32'(rd_song) >= fbs_pkg::SONG_COUNT) || (rd_frame < 16'(i_ff));
      st.len_bad   = (18'(start_ff) + 18'(qcount_ff)) > 18'(rd_len);
      st.sum_last  = (kk_ff == qcount_ff - QCW'(1));
      st.sum_ok    = (sum_ff <= max_diff_ff);
      case (pass_ff)
         2'd0:    st.keys_done = pass_done && (radius_ff == 2'd0);
         2'd1:    st.keys_done = pass_done && !radius_ff[1];
         default: st.keys_done = pass_done;
      endcase
   end

   // Memory port selection.
   always_comb begin
      case (op)
         fbs_pkg::OP_BS_RD: idx_ra = mid_sum[IAW-1:0];
         fbs_pkg::OP_BK_RD: idx_ra = IAW'(ptr_ff - CW'(1));
         default:           idx_ra = ptr_ff[IAW-1:0];
      endcase
   end

   assign qb_ra  = (op == fbs_pkg::OP_KEY_RD) ? i_ff[QAW-1:0] : kk_ff[QAW-1:0];
   assign idx_wa = req_entry_slot[IAW-1:0];
   assign idx_wd = {req_word, req_song_number, req_frame_in_song};
   assign idx_we = (op == fbs_pkg::OP_LOAD) && (req_action == fbs_pkg::ACT_INDEX) &&
                   (32'(req_entry_slot) < fbs_pkg::INDEX_DEPTH);
   assign fs_we  = (op == fbs_pkg::OP_LOAD) && (req_action == fbs_pkg::ACT_FRAME) &&
                   (32'(req_store_address) < fbs_pkg::FRAME_STORE_DEPTH);
   assign qb_we  = (op == fbs_pkg::OP_LOAD) && (req_action == fbs_pkg::ACT_QUERY) &&
                   (32'(qcount_ff) < fbs_pkg::QUERY_WORDS);

   always_comb begin
      if (op == fbs_pkg::OP_CLEAR) begin
         song_we = 1'b1;
         song_wa = clr_ff;
         song_wd = '0;
      end else begin
         song_we = (op == fbs_pkg::OP_LOAD) && (req_action == fbs_pkg::ACT_SONG) &&
                   (32'(req_song_number) < fbs_pkg::SONG_COUNT);
         song_wa = SAW'(req_song_number);
         song_wd = {req_store_address, req_song_frames};
      end
   end

   fbs_ram #(.WIDTH(58), .DEPTH(fbs_pkg::INDEX_DEPTH)) u_index_ram (
      .clock(clock), .wr_en(idx_we), .wr_addr(idx_wa), .wr_data(idx_wd),
      .rd_addr(idx_ra), .rd_data(idx_rd));

   fbs_ram #(.WIDTH(33), .DEPTH(fbs_pkg::SONG_COUNT)) u_song_ram (
      .clock(clock), .wr_en(song_we), .wr_addr(song_wa), .wr_data(song_wd),
      .rd_addr(SAW'(rd_song)), .rd_data(song_rd));

   fbs_ram #(.WIDTH(32), .DEPTH(fbs_pkg::FRAME_STORE_DEPTH)) u_frame_ram (
      .clock(clock), .wr_en(fs_we), .wr_addr(FAW'(req_store_address)), .wr_data(req_word),
      .rd_addr(bstart_ff + FAW'(kk_ff)), .rd_data(fs_rd));

   fbs_ram #(.WIDTH(32), .DEPTH(fbs_pkg::QUERY_WORDS)) u_query_ram (
      .clock(clock), .wr_en(qb_we), .wr_addr(qcount_ff[QAW-1:0]), .wr_data(req_word),
      .rd_addr(qb_ra), .rd_data(qb_rd));

   always_comb begin
      index_count_in = index_count_ff;
      max_diff_in    = max_diff_ff;
      radius_in      = radius_ff;
      qcount_in      = qcount_ff;
      overflow_in    = overflow_ff;
      clr_in         = clr_ff;
      pass_in        = pass_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      k_in           = k_ff;
      key_in         = key_ff;
      lo_in          = lo_ff;
      hx_in          = hx_ff;
      ptr_in         = ptr_ff;
      mid_in         = mid_ff;
      song_in        = song_ff;
      start_in       = start_ff;
      bstart_in      = bstart_ff;
      kk_in          = kk_ff;
      sum_in         = sum_ff;
      found_in       = found_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_song_in    = rsp_song_ff;
      rsp_diff_in    = rsp_diff_ff;
      rsp_ovf_in     = rsp_ovf_ff;

      if (csr_valid) begin
         case (csr_index)
            fbs_pkg::CSR_INDEX_COUNT: index_count_in = csr_data[CW-1:0];
            fbs_pkg::CSR_MAX_DIFF:    max_diff_in    = csr_data[DW-1:0];
            fbs_pkg::CSR_FLIP_RADIUS: radius_in      = csr_data[1:0];
            default: ;
         endcase
      end

      case (op)
         fbs_pkg::OP_CLEAR: clr_in = clr_ff + SAW'(1);
         fbs_pkg::OP_LOAD: begin
            if (req_action == fbs_pkg::ACT_QUERY) begin
               if (qb_we) qcount_in = qcount_ff + QCW'(1);
               else overflow_in = 1'b1;
               if (req_last_query) begin
                  pass_in  = 2'd0;
                  i_in     = '0;
                  j_in     = 5'd0;
                  k_in     = 5'd1;
                  found_in = 1'b0;
               end
            end
         end
         fbs_pkg::OP_KEY_CHK: begin
            key_in = key_next;
            lo_in  = '0;
            hx_in  = n_used;
         end
         fbs_pkg::OP_BS_RD: mid_in = mid_sum[IAW-1:0];
         fbs_pkg::OP_BS_CMP: begin
            if (st.key_lt) hx_in = CW'(mid_ff);
            else if (st.key_gt) lo_in = CW'(mid_ff) + CW'(1);
            else ptr_in = CW'(mid_ff);
         end
         fbs_pkg::OP_BK_CMP: begin
            if (st.key_eq) ptr_in = ptr_ff - CW'(1);
         end
         fbs_pkg::OP_ENT_CHK: begin
            song_in  = rd_song;
            start_in = rd_frame - 16'(i_ff);
            if (st.key_eq && st.frame_bad) ptr_in = ptr_ff + CW'(1);
         end
         fbs_pkg::OP_ALN_CHK: begin
            if (st.len_bad) begin
               ptr_in = ptr_ff + CW'(1);
            end else begin
               bstart_in = FAW'(rd_base) + FAW'(start_ff);
               kk_in     = '0;
               sum_in    = '0;
            end
         end
         fbs_pkg::OP_SUM_ADD: begin
            sum_in = (sum_add > (DW+1)'(fbs_pkg::DIFF_SAT)) ? fbs_pkg::DIFF_SAT :
                     sum_add[DW-1:0];
            kk_in  = kk_ff + QCW'(1);
         end
         fbs_pkg::OP_DEC: begin
            if (st.sum_ok) found_in = 1'b1;
            else ptr_in = ptr_ff + CW'(1);
         end
         fbs_pkg::OP_ADVANCE: begin
            case (pass_ff)
               2'd0: begin
                  if (last_i) begin
                     pass_in = 2'd1;
                     i_in    = '0;
                     j_in    = 5'd0;
                  end else begin
                     i_in = i_ff + QCW'(1);
                  end
               end
               2'd1: begin
                  if (j_ff == 5'd31) begin
                     j_in = 5'd0;
                     if (last_i) begin
                        pass_in = 2'd2;
                        i_in    = '0;
                        k_in    = 5'd1;
                     end else begin
                        i_in = i_ff + QCW'(1);
                     end
                  end else begin
                     j_in = j_ff + 5'd1;
                  end
               end
               default: begin
                  if (k_ff == 5'd31) begin
                     if (j_ff == 5'd30) begin
                        i_in = i_ff + QCW'(1);
                        j_in = 5'd0;
                        k_in = 5'd1;
                     end else begin
                        j_in = j_ff + 5'd1;
                        k_in = j_ff + 5'd2;
                     end
                  end else begin
                     k_in = k_ff + 5'd1;
                  end
               end
            endcase
         end
         fbs_pkg::OP_FINISH: begin
            rsp_found_in = found_ff;
            rsp_song_in  = found_ff ? song_ff : '0;
            rsp_diff_in  = found_ff ? sum_ff : '0;
            rsp_ovf_in   = overflow_ff;
            qcount_in    = '0;
            overflow_in  = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_count_ff <= '0;
         max_diff_ff    <= DW'(2867);
         radius_ff      <= 2'd0;
         qcount_ff      <= '0;
         overflow_ff    <= 1'b0;
         clr_ff         <= '0;
         found_ff       <= 1'b0;
      end else begin
         index_count_ff <= index_count_in;
         max_diff_ff    <= max_diff_in;
         radius_ff      <= radius_in;
         qcount_ff      <= qcount_in;
         overflow_ff    <= overflow_in;
         clr_ff         <= clr_in;
         found_ff       <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff      <= pass_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hx_ff        <= hx_in;
      ptr_ff       <= ptr_in;
      mid_ff       <= mid_in;
      song_ff      <= song_in;
      start_ff     <= start_in;
      bstart_ff    <= bstart_in;
      kk_ff        <= kk_in;
      sum_ff       <= sum_in;
      rsp_found_ff <= rsp_found_in;
      rsp_song_ff  <= rsp_song_in;
      rsp_diff_ff  <= rsp_diff_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_found           = rsp_found_ff;
   assign rsp_match_song      = rsp_song_ff;
   assign rsp_match_diff_bits = rsp_diff_ff;
   assign rsp_overflow        = rsp_ovf_ff;

endmodule

[hdl/fingerprint_block_search.sv]
// Fingerprint block search. The req channel carries one transaction per item:
// index entry, song descriptor, frame word or query word, selected by
// req_action. Loads and query words are taken one per cycle while idle.
// The query word with req_last_query set starts a search; req_ready stays low
// until it ends, and one transaction then appears on the rsp channel.
// A search does, per nonzero key, a binary search plus a step over each equal-key
// neighbor, and per candidate entry the alignment and the bit-difference sum,
// which walks the frame store and query buffer one word each at a time.
// The csr channel is always ready; write it only while the block is idle.
// After reset all 1024 song table entries are cleared, during which
// req_ready is low. A stalled rsp channel holds its transaction; loads and
// non-final query words are still accepted, but a new search waits until
// the pending result has been taken.
module fingerprint_block_search (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_action,
   input  logic [11:0]                req_entry_slot,
   input  logic [31:0]                req_word,
   input  logic [9:0]                 req_song_number,
   input  logic [15:0]                req_frame_in_song,
   input  logic [15:0]                req_store_address,
   input  logic [16:0]                req_song_frames,
   input  logic                       req_last_query,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_found,
   output logic [9:0]                 rsp_match_song,
   output logic [13:0]                rsp_match_diff_bits,
   output logic                       rsp_overflow,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [fbs_pkg::CSR_IW-1:0] csr_index,
   input  logic [fbs_pkg::CSR_DW-1:0] csr_data
);

   fbs_pkg::status_type st;
   fbs_pkg::op_type     op;

   assign csr_ready = 1'b1;

   fbs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_action(req_action),
      .req_last_query(req_last_query), .req_ready(req_ready), .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid), .st(st), .op(op));

   fbs_datapath u_datapath (
      .clock(clock), .reset(reset), .op(op), .st(st),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .req_action(req_action), .req_entry_slot(req_entry_slot), .req_word(req_word),
      .req_song_number(req_song_number), .req_frame_in_song(req_frame_in_song),
      .req_store_address(req_store_address), .req_song_frames(req_song_frames),
      .req_last_query(req_last_query), .rsp_found(rsp_found),
      .rsp_match_song(rsp_match_song), .rsp_match_diff_bits(rsp_match_diff_bits),
      .rsp_overflow(rsp_overflow));

endmodule

[dv/fingerprint_block_search_tb.sv]
module fingerprint_block_search_tb;

   localparam int QUIET_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_ITEMS = 250;
   localparam int MATCH_SONGS = 41;
   localparam int WRAP_SONG = 39;
   localparam int LONG_SONG = 40;
   localparam int FRAME_WORDS = 300;
   localparam int SETUP_SLOTS = 128;

   typedef struct {
      fbs_pkg::action_type act;
      bit [11:0]   slot;
      bit [31:0]   word;
      bit [9:0]    song;
      bit [15:0]   frame;
      bit [15:0]   addr;
      bit [16:0]   frames;
      bit          last;
   } req_item_type;

   typedef struct {
      bit          found;
      bit [9:0]    song;
      bit [13:0]   diff;
      bit          ovf;
   } search_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_action = '0;
   logic [11:0]         req_entry_slot = '0;
   logic [31:0]         req_word = '0;
   logic [9:0]          req_song_number = '0;
   logic [15:0]         req_frame_in_song = '0;
   logic [15:0]         req_store_address = '0;
   logic [16:0]         req_song_frames = '0;
   logic                req_last_query = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_found;
   logic [9:0]          rsp_match_song;
   logic [13:0]         rsp_match_diff_bits;
   logic                rsp_overflow;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [fbs_pkg::CSR_IW-1:0] csr_index = '0;
   logic [fbs_pkg::CSR_DW-1:0] csr_data = '0;

   // Shadow copy of the block's memories and registers.
   bit [31:0]   key_mem    [fbs_pkg::INDEX_DEPTH];
   bit [9:0]    entry_song [fbs_pkg::INDEX_DEPTH];
   bit [15:0]   entry_frame[fbs_pkg::INDEX_DEPTH];
   bit [15:0]   song_base  [fbs_pkg::SONG_COUNT];
   bit [16:0]   song_len   [fbs_pkg::SONG_COUNT];
   bit [31:0]   fstore     [fbs_pkg::FRAME_STORE_DEPTH];
   bit [31:0]   q_buf      [fbs_pkg::QUERY_WORDS];
   int unsigned q_count;
   bit          q_ovf;
   int unsigned cfg_count;
   int unsigned cfg_max_diff;
   int unsigned cfg_radius;

   search_result_type pending_matches[$];
   int          errors = 0;
   int          items_sent = 0;
   int          results_seen = 0;
   int          idle_pct = 13;
   int          hold_left = 0;
   int          quiet = 0;
   int          table_n = 0;

   fingerprint_block_search i_dut (.*);

   always #5 clock = ~clock;

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic bit align_block(input int unsigned sng, input int unsigned frm,
                                      input int unsigned pos, output int unsigned diff);
      int unsigned start;
      int unsigned sum;
      int unsigned a;
      sum = 0;
      diff = 0;
      if (sng >= fbs_pkg::SONG_COUNT || frm < pos) return 0;
      start = frm - pos;
      if (start + q_count > song_len[sng]) return 0;
      for (int k = 0; k < q_count; k++) begin
         a = (song_base[sng] + start + k) % fbs_pkg::FRAME_STORE_DEPTH;
         sum += $countones(q_buf[k] ^ fstore[a]);
         if (sum > 16383) sum = 16383;
      end
      diff = sum;
      return 1;
   endfunction

   function automatic bit try_key(input bit [31:0] key, input int unsigned pos,
                                  output int unsigned sng, output int unsigned diff);
      int n;
      int lo;
      int hi;
      int mid;
      int hit;
      int first;
      int last;
      int unsigned d;
      sng = 0;
      diff = 0;
      n = (cfg_count < fbs_pkg::INDEX_DEPTH) ? cfg_count : fbs_pkg::INDEX_DEPTH;
      lo = 0;
      hi = n - 1;
      hit = -1;
      while (hi >= lo) begin
         mid = lo + (hi - lo) / 2;
         if (key < key_mem[mid]) hi = mid - 1;
         else if (key > key_mem[mid]) lo = mid + 1;
         else begin
            hit = mid;
            break;
         end
      end
      if (hit < 0) return 0;
      first = hit;
      while (first > 0 && key_mem[first-1] == key) first--;
      last = hit;
      while (last + 1 < n && key_mem[last+1] == key) last++;
      for (int it = first; it <= last; it++) begin
         if (align_block(entry_song[it], entry_frame[it], pos, d) && d <= cfg_max_diff) begin
            sng = entry_song[it];
            diff = d;
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic search_result_type search_block();
      search_result_type r;
      int unsigned radius;
      int unsigned sng;
      int unsigned diff;
      bit [31:0] key;
      r = '{default: 0};
      radius = (cfg_radius > 2) ? 2 : cfg_radius;
      for (int i = 0; i < q_count; i++) begin
         key = q_buf[i];
         if (key != 0 && try_key(key, i, sng, diff)) begin
            r.found = 1; r.song = 10'(sng); r.diff = 14'(diff); return r;
         end
      end
      if (radius >= 1)
         for (int i = 0; i < q_count; i++)
            for (int j = 0; j < 32; j++) begin
               key = q_buf[i] ^ (32'd1 << j);
               if (key != 0 && try_key(key, i, sng, diff)) begin
                  r.found = 1; r.song = 10'(sng); r.diff = 14'(diff); return r;
               end
            end
      if (radius >= 2)
         for (int i = 0; i < q_count; i++)
            for (int j = 0; j < 31; j++)
               for (int k = j + 1; k < 32; k++) begin
                  key = q_buf[i] ^ (32'd1 << j) ^ (32'd1 << k);
                  if (key != 0 && try_key(key, i, sng, diff)) begin
                     r.found = 1; r.song = 10'(sng); r.diff = 14'(diff); return r;
                  end
               end
      return r;
   endfunction

   task automatic predict_item(input req_item_type it);
      search_result_type r;
      case (it.act)
         fbs_pkg::ACT_INDEX: begin
            key_mem[it.slot] = it.word;
            entry_song[it.slot] = it.song;
            entry_frame[it.slot] = it.frame;
         end
         fbs_pkg::ACT_SONG: begin
            song_base[it.song] = it.addr;
            song_len[it.song] = it.frames;
         end
         fbs_pkg::ACT_FRAME: fstore[it.addr] = it.word;
         default: begin
            if (q_count < fbs_pkg::QUERY_WORDS) begin
               q_buf[q_count] = it.word;
               q_count++;
            end else begin
               q_ovf = 1;
            end
            if (it.last) begin
               r = search_block();
               r.ovf = q_ovf;
               pending_matches = {pending_matches, r};
               q_count = 0;
               q_ovf = 0;
            end
         end
      endcase
   endtask

   task automatic send_item(input req_item_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_action = it.act;
      req_entry_slot = it.slot;
      req_word = it.word;
      req_song_number = it.song;
      req_frame_in_song = it.frame;
      req_store_address = it.addr;
      req_song_frames = it.frames;
      req_last_query = it.last;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_item(it);
      items_sent++;
   endtask

   // Fields that an action ignores still carry random values.
   function automatic req_item_type noise_item(input fbs_pkg::action_type act);
      req_item_type it;
      it.act = act;
      it.slot = 12'($urandom);
      it.word = $urandom;
      it.song = 10'($urandom);
      it.frame = 16'($urandom);
      it.addr = 16'($urandom);
      it.frames = 17'($urandom);
      it.last = 1'($urandom);
      return it;
   endfunction

   task automatic load_entry(input int slot, input bit [31:0] key, input int sng, input int frm);
      req_item_type it;
      it = noise_item(fbs_pkg::ACT_INDEX);
      it.slot = 12'(slot); it.word = key; it.song = 10'(sng); it.frame = 16'(frm);
      send_item(it);
   endtask

   task automatic load_song(input int sng, input int base, input int len);
      req_item_type it;
      it = noise_item(fbs_pkg::ACT_SONG);
      it.song = 10'(sng); it.addr = 16'(base); it.frames = 17'(len);
      send_item(it);
   endtask

   task automatic load_frame(input int addr, input bit [31:0] w);
      req_item_type it;
      it = noise_item(fbs_pkg::ACT_FRAME);
      it.addr = 16'(addr); it.word = w;
      send_item(it);
   endtask

   task automatic query_word(input bit [31:0] w, input bit last);
      req_item_type it;
      it = noise_item(fbs_pkg::ACT_QUERY);
      it.word = w; it.last = last;
      send_item(it);
   endtask

   task automatic csr_write(input logic [fbs_pkg::CSR_IW-1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = fbs_pkg::CSR_DW'(value);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         fbs_pkg::CSR_INDEX_COUNT: cfg_count = value & 16'h1FFF;
         fbs_pkg::CSR_MAX_DIFF:    cfg_max_diff = value & 16'h3FFF;
         fbs_pkg::CSR_FLIP_RADIUS: cfg_radius = value & 2'h3;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input int count, input int max_diff, input int radius);
      drain();
      csr_write(fbs_pkg::CSR_INDEX_COUNT, count);
      csr_write(fbs_pkg::CSR_MAX_DIFF, max_diff);
      csr_write(fbs_pkg::CSR_FLIP_RADIUS, radius);
   endtask

   function automatic bit [31:0] flip_bits(input bit [31:0] w, input int n);
      int a;
      int b;
      a = $urandom_range(0, 31);
      b = (a + $urandom_range(1, 31)) % 32;
      if (n >= 1) w[a] = ~w[a];
      if (n >= 2) w[b] = ~w[b];
      return w;
   endfunction

   // Writes a sorted table into slots 0..n-1; keys mostly copy frame words.
   task automatic build_index(input int n, input int force_song);
      bit [31:0] keys  [64];
      int        sngs  [64];
      int        frms  [64];
      bit [31:0] tk;
      int        ts;
      int        tf;
      int        len;
      int        j;
      for (int i = 0; i < n; i++) begin
         sngs[i] = (force_song >= 0) ? force_song : $urandom_range(0, MATCH_SONGS - 1);
         len = song_len[sngs[i]];
         if (len > 0 && $urandom_range(0, 3) != 0) frms[i] = $urandom_range(0, len - 1);
         else frms[i] = $urandom_range(0, 65535);
         if (i > 0 && $urandom_range(0, 3) == 0) keys[i] = keys[i-1];
         else keys[i] = fstore[(song_base[sngs[i]] + frms[i]) % fbs_pkg::FRAME_STORE_DEPTH];
         if ($urandom_range(0, 15) == 0) keys[i] = 32'd0;
      end
      for (int i = 1; i < n; i++) begin
         tk = keys[i]; ts = sngs[i]; tf = frms[i];
         j = i - 1;
         while (j >= 0 && keys[j] > tk) begin
            keys[j+1] = keys[j]; sngs[j+1] = sngs[j]; frms[j+1] = frms[j];
            j--;
         end
         keys[j+1] = tk; sngs[j+1] = ts; frms[j+1] = tf;
      end
      for (int i = 0; i < n; i++) load_entry(i, keys[i], sngs[i], frms[i]);
      table_n = n;
   endtask

   // A query block lined up on a random index entry (if aligned), with a few bits disturbed; else random words.
   task automatic send_query(input int max_len, input bit aligned);
      int s;
      int sng;
      int f;
      int len;
      int L;
      int p;
      int lo_p;
      int hi_p;
      int start;
      int r;
      bit ok;
      bit [31:0] w;
      ok = 0;
      if (aligned)
         for (int tries = 0; tries < 8 && !ok; tries++) begin
            s = $urandom_range(0, table_n - 1);
            sng = entry_song[s];
            f = entry_frame[s];
            len = song_len[sng];
            if (len > 0 && f < len) begin
               L = $urandom_range(1, (max_len < len) ? max_len : len);
               lo_p = f - (len - L);
               if (lo_p < 0) lo_p = 0;
               hi_p = (f < L - 1) ? f : L - 1;
               if (lo_p <= hi_p) begin
                  ok = 1;
                  p = $urandom_range(lo_p, hi_p);
                  start = f - p;
               end
            end
         end
      if (!ok) L = $urandom_range(1, max_len);
      for (int k = 0; k < L; k++) begin
         if (!ok) begin
            w = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
         end else if (k == p) begin
            w = flip_bits(key_mem[s], $urandom_range(0, 2));
         end else begin
            w = fstore[(song_base[sng] + start + k) % fbs_pkg::FRAME_STORE_DEPTH];
            r = $urandom_range(0, 9);
            if (r >= 5 && r < 8) w = flip_bits(w, 1);
            else if (r == 8) w = flip_bits(w, 2);
            else if (r == 9) w = $urandom;
         end
         query_word(w, k == L - 1);
      end
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = ($urandom_range(0, 99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      search_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_matches.size() == 0) begin
            report("result transaction with no search outstanding");
         end else begin
            e = pending_matches.pop_front();
            if (rsp_found !== e.found)
               report($sformatf("found %0b, want %0b", rsp_found, e.found));
            if (rsp_match_song !== e.song)
               report($sformatf("match_song %0d, want %0d", rsp_match_song, e.song));
            if (rsp_match_diff_bits !== e.diff)
               report($sformatf("match_diff_bits %0d, want %0d", rsp_match_diff_bits, e.diff));
            if (rsp_overflow !== e.ovf)
               report($sformatf("overflow %0b, want %0b", rsp_overflow, e.ovf));
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet = 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                   (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Every frame word and index slot a search can touch is written here.
   task automatic test_setup();
      int len;
      for (int a = 0; a < FRAME_WORDS; a++) load_frame(a, $urandom);
      for (int a = 65528; a < 65536; a++) load_frame(a, $urandom);
      for (int sn = 0; sn < WRAP_SONG; sn++) begin
         len = $urandom_range(1, 64);
         load_song(sn, $urandom_range(0, FRAME_WORDS - len), len);
      end
      load_song(WRAP_SONG, 65528, 24);
      load_song(LONG_SONG, 0, FRAME_WORDS);
      load_song(fbs_pkg::SONG_COUNT - 1, 0, 65536);
      for (int i = 0; i < SETUP_SLOTS; i++)
         load_entry(i, (i << 25) | $urandom_range(0, 25'h1FFFFFF),
                    $urandom_range(0, MATCH_SONGS - 1),
                    $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 65535));
   endtask

   task automatic test_full_index();
      configure(SETUP_SLOTS, 16383, 0);
      table_n = SETUP_SLOTS;
      repeat (4) send_query(4, 1);
      configure(SETUP_SLOTS, 40, 0);
      send_query(4, 1);
      configure(0, 16383, 0);
      send_query(3, 0);
   endtask

   task automatic test_thresholds();
      configure(16, 0, 0);
      build_index(16, -1);
      repeat (3) send_query(6, 1);
      configure(16, 16383, 0);
      repeat (3) send_query(6, 1);
   endtask

   task automatic test_flip_radius();
      configure(8, 12, 1);
      build_index(8, -1);
      repeat (2) send_query(4, 1);
      configure(8, 12, 2);
      repeat (2) send_query(3, 1);
      configure(8, 12, 3);
      send_query(3, 1);
   endtask

   task automatic test_wrap_song();
      configure(6, 30, 0);
      build_index(6, WRAP_SONG);
      repeat (3) send_query(8, 1);
   endtask

   task automatic test_overflow();
      configure(12, 4000, 0);
      build_index(12, LONG_SONG);
      for (int k = 0; k < fbs_pkg::QUERY_WORDS + 2; k++)
         query_word($urandom_range(0, 1) ? fstore[k] : $urandom,
                    k == fbs_pkg::QUERY_WORDS + 1);
   endtask

   task automatic test_backpressure();
      configure(16, 30, 0);
      build_index(16, -1);
      drain();
      hold_left = 2500;
      repeat (4) send_query(2, 1);
   endtask

   task automatic test_random();
      int start_items;
      int radius;
      int n;
      int md;
      int phase;
      int len;
      int sn;
      start_items = items_sent;
      phase = 0;
      while (items_sent - start_items < RANDOM_ITEMS) begin
         idle_pct = (phase == 1) ? 0 : 13;
         radius = $urandom_range(0, 9);
         radius = (radius < 5) ? 0 : (radius < 8) ? 1 : (radius == 8) ? 2 : 3;
         n = $urandom_range(2, 32);
         case ($urandom_range(0, 3))
            0: md = $urandom_range(0, 8);
            1: md = 16383;
            default: md = $urandom_range(0, 60);
         endcase
         configure(n, md, radius);
         build_index(n, -1);
         repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 2))
               0: load_frame($urandom_range(0, 65535), $urandom);
               1: begin
                  sn = $urandom_range(0, WRAP_SONG - 1);
                  len = $urandom_range(1, 64);
                  load_song(sn, $urandom_range(0, FRAME_WORDS - len), len);
               end
               default: load_song($urandom_range(MATCH_SONGS, fbs_pkg::SONG_COUNT - 1),
                                  $urandom_range(0, 65535), $urandom_range(0, 65536));
            endcase
         end
         repeat ($urandom_range(1, 5))
            send_query((radius == 0) ? 16 : (radius == 1) ? 8 : 4, $urandom_range(0, 4) != 0);
         phase++;
      end
      idle_pct = 13;
   endtask

   initial begin
      cfg_count = 0;
      cfg_max_diff = 2867;
      cfg_radius = 0;
      q_count = 0;
      q_ovf = 0;
      foreach (song_base[i]) begin
         song_base[i] = '0;
         song_len[i] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_setup();
      test_full_index();
      test_thresholds();
      test_flip_radius();
      test_wrap_song();
      test_overflow();
      test_backpressure();
      test_random();
      drain();
      $display("Sent %0d transactions and checked %0d search results,", items_sent, results_seen);
      $display("covering a large index, flip radii, threshold extremes, overflow and stalls.");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
